// File: rtl/tpfc_pkg.sv
// ----------------------------------------------------------------------------
// tpfc_pkg
// Format codes and stage payload types of the pixel format converter.
// ----------------------------------------------------------------------------
package tpfc_pkg;

  localparam int FmtW = 4;

  localparam logic [FmtW-1:0] FMT_L    = 4'd0;
  localparam logic [FmtW-1:0] FMT_A    = 4'd1;
  localparam logic [FmtW-1:0] FMT_R    = 4'd2;
  localparam logic [FmtW-1:0] FMT_LA   = 4'd3;
  localparam logic [FmtW-1:0] FMT_RGB  = 4'd4;
  localparam logic [FmtW-1:0] FMT_BGR  = 4'd5;
  localparam logic [FmtW-1:0] FMT_RGBA = 4'd6;
  localparam logic [FmtW-1:0] FMT_BGRA = 4'd7;
  localparam logic [FmtW-1:0] FMT_YUY2 = 4'd8;

  localparam logic CFG_SRC = 1'b0;
  localparam logic CFG_DST = 1'b1;

  typedef struct packed {
    logic              is_yuv;
    logic              bgr;
    logic signed [8:0] c;
    logic signed [8:0] d;
    logic signed [8:0] e;
    logic [31:0]       pix;
    logic              unsup;
    logic              last;
  } op_t;

  typedef struct packed {
    logic               is_yuv;
    logic               bgr;
    logic signed [17:0] p298c;
    logic signed [16:0] p409e;
    logic signed [14:0] p100d;
    logic signed [15:0] p208e;
    logic signed [17:0] p516d;
    logic [31:0]        pix;
    logic               unsup;
    logic               last;
  } prod_t;

endpackage

// File: rtl/tpfc_issue.sv
// ----------------------------------------------------------------------------
// tpfc_issue
// Input register and decode stage: builds the byte placement result and
// splits a YUY2 word into two pixel operations.
// ----------------------------------------------------------------------------
module tpfc_issue import tpfc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [FmtW-1:0] src_fmt,
  input  logic [FmtW-1:0] dst_fmt,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     source_pixel,
  output logic            op_valid,
  input  logic            op_stall,
  output op_t             op
);

  typedef struct packed {
    logic [31:0] pix;
    logic        unsup;
    logic        is_yuv;
  } conv_t;

  function automatic logic [31:0] size_mask(input logic [FmtW-1:0] f);
    logic [31:0] m;
    unique case (f)
      FMT_L, FMT_A, FMT_R: m = 32'h0000_00FF;
      FMT_LA:              m = 32'h0000_FFFF;
      FMT_RGB, FMT_BGR:    m = 32'h00FF_FFFF;
      default:             m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic conv_t convert(input logic [FmtW-1:0] s, input logic [FmtW-1:0] d,
                                    input logic [31:0] w);
    conv_t       o;
    logic [7:0]  b0, b1, b2, b3;
    logic        s_lr, s_4, s_3, d_4, d_3;
    b0   = w[7:0];
    b1   = w[15:8];
    b2   = w[23:16];
    b3   = w[31:24];
    s_lr = (s == FMT_L) || (s == FMT_R);
    s_4  = (s == FMT_RGBA) || (s == FMT_BGRA);
    s_3  = (s == FMT_RGB) || (s == FMT_BGR);
    d_4  = (d == FMT_RGBA) || (d == FMT_BGRA);
    d_3  = (d == FMT_RGB) || (d == FMT_BGR);
    o.pix    = '0;
    o.unsup  = 1'b0;
    o.is_yuv = 1'b0;
    priority if (s == FMT_L && d == FMT_LA)          o.pix = {16'h0, b0, 8'hFF};
    else if (s == FMT_LA && d == FMT_L)              o.pix = {24'h0, b1};
    else if (s == FMT_A && d == FMT_LA)              o.pix = {16'h0, 8'hFF, b0};
    else if (s == FMT_LA && d == FMT_A)              o.pix = {24'h0, b0};
    else if (s_lr && d_4)                            o.pix = {8'hFF, b0, b0, b0};
    else if (s_4 && d == FMT_L)                      o.pix = {24'h0, b0};
    else if (s_lr && d_3)                            o.pix = {8'h00, b0, b0, b0};
    else if (s_3 && (d == FMT_L || d == FMT_R))      o.pix = {24'h0, b0};
    else if (s == FMT_A && d_4)                      o.pix = {b0, 24'hFF_FFFF};
    else if (s_4 && d == FMT_A)                      o.pix = {24'h0, b3};
    else if (s == FMT_LA && d_4)                     o.pix = {b1, b0, b0, b0};
    else if (s_4 && d == FMT_LA)                     o.pix = {16'h0, b3, b0};
    else if ((s == FMT_RGB && d == FMT_RGBA) || (s == FMT_BGR && d == FMT_BGRA))
      o.pix = {8'hFF, b2, b1, b0};
    else if ((s == FMT_RGBA && d == FMT_RGB) || (s == FMT_BGRA && d == FMT_BGR))
      o.pix = {8'h00, b2, b1, b0};
    else if ((s == FMT_RGB && d == FMT_BGRA) || (s == FMT_BGR && d == FMT_RGBA))
      o.pix = {8'hFF, b0, b1, b2};
    else if ((s == FMT_BGRA && d == FMT_RGB) || (s == FMT_RGBA && d == FMT_BGR))
      o.pix = {8'h00, b0, b1, b2};
    else if ((s == FMT_RGB && d == FMT_BGR) || (s == FMT_BGR && d == FMT_RGB))
      o.pix = {8'h00, b0, b1, b2};
    else if ((s == FMT_RGBA && d == FMT_BGRA) || (s == FMT_BGRA && d == FMT_RGBA))
      o.pix = {b3, b0, b1, b2};
    else if (s == FMT_YUY2 && d_4)                   o.is_yuv = 1'b1;
    else if (s == d)                                 o.pix = w & size_mask(s);
    else                                             o.unsup = 1'b1;
    return o;
  endfunction

  logic        v0;
  logic [31:0] word0;
  logic        half;
  logic        v1;
  op_t         op1;

  conv_t       cv;
  logic        move1;
  logic        fire;
  logic        done;
  logic [7:0]  ysel;
  op_t         op_next;

  always_comb begin
    cv    = convert(src_fmt, dst_fmt, word0);
    move1 = !(v1 && op_stall);
    fire  = v0 && move1;
    done  = fire && (!cv.is_yuv || half);
    in_stall = v0 && !done;
    ysel  = half ? word0[23:16] : word0[7:0];
    op_next.is_yuv = cv.is_yuv;
    op_next.bgr    = (dst_fmt == FMT_BGRA);
    op_next.c      = $signed({1'b0, ysel} - 9'd16);
    op_next.d      = $signed({1'b0, word0[15:8]} - 9'd128);
    op_next.e      = $signed({1'b0, word0[31:24]} - 9'd128);
    op_next.pix    = cv.pix;
    op_next.unsup  = cv.unsup;
    op_next.last   = !cv.is_yuv || half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      half <= 1'b0;
    end else if (!in_stall) begin
      v0   <= in_valid;
      half <= 1'b0;
    end else if (fire) begin
      half <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      word0 <= source_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (move1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      op1 <= op_next;
    end
  end

  assign op_valid = v1;
  assign op       = op1;

endmodule

// File: rtl/tpfc_yuv_mul.sv
// ----------------------------------------------------------------------------
// tpfc_yuv_mul
// Product stage: forms the BT.601 coefficient products of one pixel.
// ----------------------------------------------------------------------------
module tpfc_yuv_mul import tpfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  op_valid,
  output logic  op_stall,
  input  op_t   op,
  output logic  prod_valid,
  input  logic  prod_stall,
  output prod_t prod
);

  logic  v2;
  prod_t prod2;
  prod_t prod_next;
  logic  move2;

  always_comb begin
    move2 = !(v2 && prod_stall);
    prod_next.is_yuv = op.is_yuv;
    prod_next.bgr    = op.bgr;
    prod_next.p298c  = 18'(op.c) * 18'sd298;
    prod_next.p409e  = 17'(op.e) * 17'sd409;
    prod_next.p100d  = 15'(op.d) * 15'sd100;
    prod_next.p208e  = 16'(op.e) * 16'sd208;
    prod_next.p516d  = 18'(op.d) * 18'sd516;
    prod_next.pix    = op.pix;
    prod_next.unsup  = op.unsup;
    prod_next.last   = op.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (move2) begin
      v2 <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      prod2 <= prod_next;
    end
  end

  assign op_stall   = !move2;
  assign prod_valid = v2;
  assign prod       = prod2;

endmodule

// File: rtl/tpfc_yuv_sum.sv
// ----------------------------------------------------------------------------
// tpfc_yuv_sum
// Sum, clamp and pack stage with the output register.
// ----------------------------------------------------------------------------
module tpfc_yuv_sum import tpfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        prod_valid,
  output logic        prod_stall,
  input  prod_t       prod,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] dest_pixel,
  output logic        unsupported,
  output logic        last_of_item
);

  function automatic logic [7:0] clamp(input logic signed [19:0] v);
    logic [7:0] o;
    priority if (v[19])  o = 8'h00;
    else if (|v[18:16])  o = 8'hFF;
    else                 o = v[15:8];
    return o;
  endfunction

  logic               v3;
  logic [31:0]        pix3;
  logic               unsup3;
  logic               last3;
  logic               move3;
  logic signed [19:0] sum_r;
  logic signed [19:0] sum_g;
  logic signed [19:0] sum_b;
  logic [7:0]         ch_r;
  logic [7:0]         ch_g;
  logic [7:0]         ch_b;
  logic [31:0]        pix_next;

  always_comb begin
    move3 = !(v3 && out_stall);
    sum_r = 20'(prod.p298c) + 20'(prod.p409e) + 20'sd128;
    sum_g = 20'(prod.p298c) - 20'(prod.p100d) - 20'(prod.p208e) + 20'sd128;
    sum_b = 20'(prod.p298c) + 20'(prod.p516d) + 20'sd128;
    ch_r  = clamp(sum_r);
    ch_g  = clamp(sum_g);
    ch_b  = clamp(sum_b);
    if (!prod.is_yuv) begin
      pix_next = prod.pix;
    end else if (prod.bgr) begin
      pix_next = {8'h00, ch_r, ch_g, ch_b};
    end else begin
      pix_next = {8'h00, ch_b, ch_g, ch_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (move3) begin
      v3 <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move3) begin
      pix3   <= pix_next;
      unsup3 <= prod.unsup;
      last3  <= prod.last;
    end
  end

  assign prod_stall   = !move3;
  assign out_valid    = v3;
  assign dest_pixel   = pix3;
  assign unsupported  = unsup3;
  assign last_of_item = last3;

endmodule

// File: rtl/texture_pixel_format_converter_unit.sv
// ----------------------------------------------------------------------------
// texture_pixel_format_converter_unit
// Each result passes the input, decode, product and output registers in turn.
// Throughput: one item per cycle while the output is not stalled; a YUY2 item
// holds the input until both of its pixels are issued.
// Reset clears all valid bits and sets both format registers to L8.
// ----------------------------------------------------------------------------
module texture_pixel_format_converter_unit import tpfc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [FmtW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     source_pixel,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     dest_pixel,
  output logic            unsupported,
  output logic            last_of_item
);

  logic [FmtW-1:0] source_format;
  logic [FmtW-1:0] dest_format;

  logic  op_valid;
  logic  op_stall;
  op_t   op;
  logic  prod_valid;
  logic  prod_stall;
  prod_t prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_L;
      dest_format   <= FMT_L;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SRC: source_format <= cfg_data;
        CFG_DST: dest_format   <= cfg_data;
        default: ;
      endcase
    end
  end

  tpfc_issue u_issue (
    .clk          (clk),
    .rst          (rst),
    .src_fmt      (source_format),
    .dst_fmt      (dest_format),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_pixel (source_pixel),
    .op_valid     (op_valid),
    .op_stall     (op_stall),
    .op           (op)
  );

  tpfc_yuv_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .op_stall   (op_stall),
    .op         (op),
    .prod_valid (prod_valid),
    .prod_stall (prod_stall),
    .prod       (prod)
  );

  tpfc_yuv_sum u_sum (
    .clk          (clk),
    .rst          (rst),
    .prod_valid   (prod_valid),
    .prod_stall   (prod_stall),
    .prod         (prod),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dest_pixel   (dest_pixel),
    .unsupported  (unsupported),
    .last_of_item (last_of_item)
  );

  a_unsup_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported |-> dest_pixel == 32'h0 && last_of_item)
    else $error("unsupported result carries data or is not last");

  a_first_half_yuv: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_item |-> !unsupported && dest_pixel[31:24] == 8'h00)
    else $error("first result of an item is not a YUY2 pixel");

  a_first_half_follow: assert property (@(posedge clk) disable iff (rst)
    op_valid && !op_stall && !op.last |=> op_valid && op.last)
    else $error("second YUY2 pixel does not follow the first");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
